[design/spiadc_pkg.sv]
// shared types and constants of the spi slave adc command handler
`default_nettype none

package spiadc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_DONE = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_MAX_CHANNEL = 2'd0,
    CFG_PRESENCE    = 2'd1,
    CFG_THRESHOLD   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] GO_LOW_FIRST  = 8'h80;
  localparam logic [7:0] GO_HIGH_FIRST = 8'hC0;
  localparam logic [7:0] DATA_CMD      = 8'h90;
  localparam logic [7:0] ZERO_CMD      = 8'h00;
  localparam logic [7:0] CFG_CMD       = 8'h40;
  localparam int         ORDER_BIT     = 6;

  localparam logic [3:0] MAX_CHANNEL_RST = 4'd11;
  localparam logic [7:0] PRESENCE_RST    = 8'd76;
  localparam logic [7:0] THRESHOLD_RST   = 8'd10;

  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 24;

  typedef struct packed {
    op_t         opcode;
    logic [7:0]  rx_byte;
    logic [15:0] sample;
  } in_word_t;

  typedef struct packed {
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       start_conversion;
    logic       abort_conversion;
    logic [3:0] conv_channel;
    logic       watchdog_kick;
    logic       timer_restart;
    logic       link_up;
    logic       data_ready;
  } result_t;

endpackage

`default_nettype wire

[design/spiadc_in_stage.sv]
// input register of the event stream
`default_nettype none

module spiadc_in_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire spiadc_pkg::in_word_t s_word,
  input  wire logic                advance,
  output logic                     word_valid,
  output spiadc_pkg::in_word_t     word
);
  import spiadc_pkg::*;

  logic take;

  assign s_tready = !word_valid || advance;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (take) begin
      word_valid <= 1'b1;
    end else if (advance) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word <= s_word;
    end
  end

endmodule

`default_nettype wire

[design/spiadc_core.sv]
// command decode, link state and config registers
`default_nettype none

module spiadc_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 advance,
  input  wire spiadc_pkg::in_word_t word,
  output spiadc_pkg::result_t       result
);
  import spiadc_pkg::*;

  logic [3:0] max_channel;
  logic [7:0] presence_byte;
  logic [7:0] activity_threshold;

  logic [SAMPLE_BITS-1:0] sample_store, sample_store_next;
  logic [3:0]             current_channel, current_channel_next;
  logic                   upper_first, upper_first_next;
  logic                   alternate_low, alternate_low_next;
  logic                   sample_valid, sample_valid_next;
  logic                   converting, converting_next;
  logic                   link_flag, link_flag_next;
  logic [COUNT_BITS-1:0]  byte_count, byte_count_next;
  logic [COUNT_BITS-1:0]  last_read_count, last_read_count_next;

  logic [COUNT_BITS-1:0] distance;
  logic [15:0]           sample_ext;
  logic [15:0]           new_sample_ext;
  logic                  is_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_channel        <= MAX_CHANNEL_RST;
      presence_byte      <= PRESENCE_RST;
      activity_threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_CHANNEL: max_channel        <= cfg_data[3:0];
        CFG_PRESENCE:    presence_byte      <= cfg_data;
        CFG_THRESHOLD:   activity_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample_ext     = 16'(sample_store);
  assign new_sample_ext = 16'(word.sample[SAMPLE_BITS-1:0]);
  assign distance       = byte_count - last_read_count;
  assign is_go = (word.rx_byte[7:4] == GO_LOW_FIRST[7:4])
              || (word.rx_byte[7:4] == GO_HIGH_FIRST[7:4]);

  always_comb begin
    sample_store_next    = sample_store;
    current_channel_next = current_channel;
    upper_first_next     = upper_first;
    alternate_low_next   = alternate_low;
    sample_valid_next    = sample_valid;
    converting_next      = converting;
    link_flag_next       = link_flag;
    byte_count_next      = byte_count;
    last_read_count_next = last_read_count;
    result               = '0;

    unique case (word.opcode)
      OP_RX: begin
        byte_count_next = byte_count + 1'b1;
        if (is_go) begin
          sample_valid_next  = 1'b0;
          alternate_low_next = 1'b1;
          upper_first_next   = word.rx_byte[ORDER_BIT];
          if (word.rx_byte[3:0] > max_channel) begin
            current_channel_next = '0;
          end else begin
            current_channel_next = word.rx_byte[3:0];
          end
          if (!converting) begin
            sample_store_next       = '1;
            result.start_conversion = 1'b1;
            converting_next         = 1'b1;
          end else begin
            result.abort_conversion = 1'b1;
            converting_next         = 1'b0;
            result.tx_load          = 1'b1;
            result.tx_byte          = presence_byte;
          end
          result.watchdog_kick = 1'b1;
          result.timer_restart = 1'b1;
          link_flag_next       = 1'b1;
        end
        if (word.rx_byte == CFG_CMD) begin
          result.tx_load = 1'b1;
          result.tx_byte = presence_byte;
        end
        if (word.rx_byte == ZERO_CMD && sample_valid) begin
          last_read_count_next = byte_count_next;
          result.tx_load       = 1'b1;
          result.tx_byte       = alternate_low ? sample_ext[7:0] : sample_ext[15:8];
          alternate_low_next   = !alternate_low;
        end
        if (word.rx_byte == DATA_CMD) begin
          result.tx_load = 1'b1;
          if (sample_valid) begin
            result.tx_byte       = upper_first ? sample_ext[7:0] : sample_ext[15:8];
            last_read_count_next = byte_count_next;
          end else begin
            result.tx_byte = presence_byte;
          end
        end
      end
      OP_DONE: begin
        sample_store_next = word.sample[SAMPLE_BITS-1:0];
        result.tx_load    = 1'b1;
        result.tx_byte    = upper_first ? new_sample_ext[15:8] : new_sample_ext[7:0];
        sample_valid_next = 1'b1;
        converting_next   = 1'b0;
      end
      OP_TICK: begin
        result.timer_restart = 1'b1;
        result.watchdog_kick = (distance < COUNT_BITS'(activity_threshold));
        link_flag_next       = 1'b0;
      end
      OP_NONE: ;
      default: ;
    endcase

    result.conv_channel = current_channel_next;
    result.link_up      = link_flag_next;
    result.data_ready   = sample_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_store    <= '0;
      current_channel <= '0;
      upper_first     <= 1'b0;
      alternate_low   <= 1'b0;
      sample_valid    <= 1'b0;
      converting      <= 1'b0;
      link_flag       <= 1'b0;
      byte_count      <= '0;
      last_read_count <= '0;
    end else if (advance) begin
      sample_store    <= sample_store_next;
      current_channel <= current_channel_next;
      upper_first     <= upper_first_next;
      alternate_low   <= alternate_low_next;
      sample_valid    <= sample_valid_next;
      converting      <= converting_next;
      link_flag       <= link_flag_next;
      byte_count      <= byte_count_next;
      last_read_count <= last_read_count_next;
    end
  end

  a_go_abort_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && word.opcode == OP_RX && is_go && converting) |=> !converting)
    else $error("abort did not clear converting");

  a_done_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (advance && word.opcode == OP_DONE) |=> (sample_valid && !converting))
    else $error("conversion done did not mark sample valid");

  a_go_start_fills: assert property (@(posedge clk) disable iff (rst)
    (advance && result.start_conversion) |=> (converting && !sample_valid
      && sample_store == '1))
    else $error("conversion start left stale sample state");

  a_tick_drops_link: assert property (@(posedge clk) disable iff (rst)
    (advance && word.opcode == OP_TICK) |=> !link_flag)
    else $error("tick did not drop the link");

  a_channel_in_range: assert property (@(posedge clk) disable iff (rst)
    (advance && word.opcode == OP_RX && is_go) |=>
      (current_channel <= $past(max_channel)))
    else $error("selected channel beyond max_channel");

endmodule

`default_nettype wire

[design/spiadc_out_stage.sv]
// result register of the response stream
`default_nettype none

module spiadc_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire spiadc_pkg::result_t result,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output spiadc_pkg::result_t      m_result,
  output logic                     free
);
  import spiadc_pkg::*;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_result <= result;
    end
  end

endmodule

`default_nettype wire

[design/spi_slave_adc_command_handler.sv]
// top level of the spi slave adc command handler
// path: a word accepted into the input register is decoded and its result is registered
//   in the result register, which drives m_tdata
// throughput: one word per cycle while m_tready does not hold the result register, set by
//   the single decode stage between the input register and the result register
// reset: synchronous rst clears all link state and restores the config defaults
`default_nettype none

module spi_slave_adc_command_handler (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_we,
  input  wire logic [1:0]                              cfg_index,
  input  wire logic [7:0]                              cfg_data,
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  input  wire logic [spiadc_pkg::IN_DATA_BITS-1:0]     s_tdata,  // rx_byte, sample
  input  wire logic [1:0]                              s_tuser,  // opcode
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  // tx_load, tx_byte, start_conversion, abort_conversion, conv_channel,
  // watchdog_kick, timer_restart, link_up, data_ready
  output logic [spiadc_pkg::OUT_DATA_BITS-1:0]         m_tdata
);
  import spiadc_pkg::*;

  in_word_t s_word;
  in_word_t word;
  logic     word_valid;
  logic     out_free;
  logic     advance;
  result_t  result;
  result_t  m_result;

  assign s_word.opcode  = op_t'(s_tuser);
  assign s_word.rx_byte = s_tdata[7:0];
  assign s_word.sample  = s_tdata[23:8];

  assign advance = word_valid && out_free;

  spiadc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_word     (s_word),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  spiadc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .word      (word),
    .result    (result)
  );

  spiadc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (m_result),
    .free     (out_free)
  );

  assign m_tdata = {5'b0,
                    m_result.data_ready,
                    m_result.link_up,
                    m_result.timer_restart,
                    m_result.watchdog_kick,
                    m_result.conv_channel,
                    m_result.abort_conversion,
                    m_result.start_conversion,
                    m_result.tx_byte,
                    m_result.tx_load};

endmodule

`default_nettype wire
